>>> src/v3alu_pkg.sv
// ============================================================================
// v3alu_pkg
// Shared constants, item types and datapath step functions of the vector ALU.
// ============================================================================
package v3alu_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
	localparam int SAT_BITS  = (2 * WORD_BITS + 2 > NUM_BITS + 2) ? 2 * WORD_BITS + 2
		: NUM_BITS + 2;

	localparam int OP_BITS   = 4;
	localparam int KIND_BITS = 4;

	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam int IN_DATA_BITS  = ((7 * WORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((4 * WORD_BITS + 7) / 8) * 8;

	// operation codes on the input tuser
	localparam logic [OP_BITS-1:0] OP_ADD   = 4'd0;
	localparam logic [OP_BITS-1:0] OP_SUB   = 4'd1;
	localparam logic [OP_BITS-1:0] OP_NEG   = 4'd2;
	localparam logic [OP_BITS-1:0] OP_SCALE = 4'd3;
	localparam logic [OP_BITS-1:0] OP_DIV   = 4'd4;
	localparam logic [OP_BITS-1:0] OP_DOT   = 4'd5;
	localparam logic [OP_BITS-1:0] OP_SQMAG = 4'd6;
	localparam logic [OP_BITS-1:0] OP_CROSS = 4'd7;
	localparam logic [OP_BITS-1:0] OP_MAG   = 4'd8;
	localparam logic [OP_BITS-1:0] OP_NORM  = 4'd9;

	// internal work kinds, unused codes fold into K_NONE
	localparam logic [KIND_BITS-1:0] K_NONE  = 4'd0;
	localparam logic [KIND_BITS-1:0] K_ADD   = 4'd1;
	localparam logic [KIND_BITS-1:0] K_SUB   = 4'd2;
	localparam logic [KIND_BITS-1:0] K_NEG   = 4'd3;
	localparam logic [KIND_BITS-1:0] K_SCALE = 4'd4;
	localparam logic [KIND_BITS-1:0] K_DIV   = 4'd5;
	localparam logic [KIND_BITS-1:0] K_DOT   = 4'd6;
	localparam logic [KIND_BITS-1:0] K_SQMAG = 4'd7;
	localparam logic [KIND_BITS-1:0] K_CROSS = 4'd8;
	localparam logic [KIND_BITS-1:0] K_MAG   = 4'd9;
	localparam logic [KIND_BITS-1:0] K_NORM  = 4'd10;

	localparam logic signed [SAT_BITS-1:0] SAT_HI =
		{{(SAT_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [SAT_BITS-1:0] SAT_LO =
		{{(SAT_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic [KIND_BITS-1:0]          kind;
		logic                          dz;
		logic [2:0][WORD_BITS-1:0]     a;
		logic [2:0][WORD_BITS-1:0]     b;
		logic [WORD_BITS-1:0]          s;
	} item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]          kind;
		logic                          err;
		logic [2:0][WORD_BITS-1:0]     a;
		logic [WORD_BITS-1:0]          s;
		logic [2:0][WORD_BITS-1:0]     v;
		logic [WORD_BITS-1:0]          sc;
		logic [PROD_BITS-1:0]          n;
		logic [WORD_BITS:0]            srem;
		logic [WORD_BITS-1:0]          root;
		logic [WORD_BITS-1:0]          d;
		logic [2:0][NUM_BITS-1:0]      num;
		logic [2:0][WORD_BITS-1:0]     drem;
		logic [2:0][NUM_BITS-1:0]      quo;
		logic [2:0]                    neg;
	} pipe_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]          kind;
		logic                          err;
		logic [2:0][WORD_BITS-1:0]     v;
		logic [WORD_BITS-1:0]          sc;
	} res_t;

	function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [SAT_BITS-1:0] x);
		if (x > SAT_HI)
			return WORD_MAX;
		else if (x < SAT_LO)
			return WORD_MIN;
		else
			return x[WORD_BITS-1:0];
	endfunction

	function automatic logic signed [SAT_BITS-1:0] sext_word(input logic [WORD_BITS-1:0] x);
		return {{(SAT_BITS-WORD_BITS){x[WORD_BITS-1]}}, x};
	endfunction

	function automatic logic signed [SAT_BITS-1:0] sext_prod(input logic [PROD_BITS-1:0] x);
		return {{(SAT_BITS-PROD_BITS){x[PROD_BITS-1]}}, x};
	endfunction

	function automatic logic [WORD_BITS-1:0] abs_word(input logic [WORD_BITS-1:0] x);
		return x[WORD_BITS-1] ? (~x + 1'b1) : x;
	endfunction

	// one root bit per call: bring down two radicand bits, try (root<<2)|1
	function automatic pipe_t sqrt_step(input pipe_t x);
		pipe_t                y;
		logic [WORD_BITS+1:0] remt;
		logic [WORD_BITS+1:0] trial;
		logic                 take;
		y     = x;
		remt  = {x.srem[WORD_BITS-1:0], x.n[PROD_BITS-1 -: 2]};
		trial = {x.root, 2'b01};
		take  = (remt >= trial);
		y.srem = take ? (WORD_BITS+1)'(remt - trial) : remt[WORD_BITS:0];
		y.root = {x.root[WORD_BITS-2:0], take};
		y.n    = {x.n[PROD_BITS-3:0], 2'b00};
		return y;
	endfunction

	// one quotient bit per call on each of the three lanes
	function automatic pipe_t div_step(input pipe_t x);
		pipe_t              y;
		logic [WORD_BITS:0] remt;
		logic               take;
		y = x;
		for (int i = 0; i < 3; i++) begin
			remt = {x.drem[i], x.num[i][NUM_BITS-1]};
			take = (remt >= {1'b0, x.d});
			y.drem[i] = take ? WORD_BITS'(remt - {1'b0, x.d}) : remt[WORD_BITS-1:0];
			y.quo[i]  = {x.quo[i][NUM_BITS-2:0], take};
			y.num[i]  = {x.num[i][NUM_BITS-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

>>> src/v3alu_front.sv
// ============================================================================
// v3alu_front
// Accepts input words, decodes the operation and queues them for the back end.
// ============================================================================
module v3alu_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [v3alu_pkg::OP_BITS-1:0]            in_op,
	input  logic [2:0][v3alu_pkg::WORD_BITS-1:0]     in_a,
	input  logic [2:0][v3alu_pkg::WORD_BITS-1:0]     in_b,
	input  logic [v3alu_pkg::WORD_BITS-1:0]          in_s,
	output logic                                     q_valid,
	input  logic                                     q_ready,
	output v3alu_pkg::item_t                         q_item
);

	v3alu_pkg::item_t                        cls;
	v3alu_pkg::item_t                        mem_q [v3alu_pkg::QDEPTH];
	logic [v3alu_pkg::QPTR_BITS-1:0]         wr_q;
	logic [v3alu_pkg::QPTR_BITS-1:0]         rd_q;
	logic [v3alu_pkg::QCNT_BITS-1:0]         cnt_q;
	logic                                    push;
	logic                                    pop;

	always_comb begin
		cls.a  = in_a;
		cls.b  = in_b;
		cls.s  = in_s;
		cls.dz = (in_s == '0);
		case (in_op)
			v3alu_pkg::OP_ADD:   cls.kind = v3alu_pkg::K_ADD;
			v3alu_pkg::OP_SUB:   cls.kind = v3alu_pkg::K_SUB;
			v3alu_pkg::OP_NEG:   cls.kind = v3alu_pkg::K_NEG;
			v3alu_pkg::OP_SCALE: cls.kind = v3alu_pkg::K_SCALE;
			v3alu_pkg::OP_DIV:   cls.kind = v3alu_pkg::K_DIV;
			v3alu_pkg::OP_DOT:   cls.kind = v3alu_pkg::K_DOT;
			v3alu_pkg::OP_SQMAG: cls.kind = v3alu_pkg::K_SQMAG;
			v3alu_pkg::OP_CROSS: cls.kind = v3alu_pkg::K_CROSS;
			v3alu_pkg::OP_MAG:   cls.kind = v3alu_pkg::K_MAG;
			v3alu_pkg::OP_NORM:  cls.kind = v3alu_pkg::K_NORM;
			default:             cls.kind = v3alu_pkg::K_NONE;
		endcase
	end

	assign in_ready = (cnt_q != v3alu_pkg::QCNT_BITS'(v3alu_pkg::QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= QPTR_NEXT(wr_q);
			if (pop)
				rd_q <= QPTR_NEXT(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= cls;
	end

	function automatic logic [v3alu_pkg::QPTR_BITS-1:0] QPTR_NEXT(
		input logic [v3alu_pkg::QPTR_BITS-1:0] p);
		if (p == v3alu_pkg::QPTR_BITS'(v3alu_pkg::QDEPTH - 1))
			return '0;
		else
			return p + 1'b1;
	endfunction

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance on push");

endmodule

>>> src/v3alu_back.sv
// ============================================================================
// v3alu_back
// Pipelined datapath: products, sums, root extraction, three-lane divide.
// ============================================================================
module v3alu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  v3alu_pkg::item_t   in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output v3alu_pkg::res_t    out_res
);

	localparam int WB = v3alu_pkg::WORD_BITS;
	localparam int NB = v3alu_pkg::NUM_BITS;
	localparam int PB = v3alu_pkg::PROD_BITS;
	localparam int SB = v3alu_pkg::SAT_BITS;

	logic                          adv;

	logic                          vld_s1;
	v3alu_pkg::item_t              item_s1;

	logic                          vld_s2;
	logic [v3alu_pkg::KIND_BITS-1:0] kind_s2;
	logic                          dz_s2;
	logic [2:0][WB-1:0]            a_s2;
	logic [WB-1:0]                 s_s2;
	logic [2:0][WB-1:0]            vadd_s2;
	logic [PB-1:0]                 prod_s2 [6];

	logic [WB:0]                   sqrt_vld;
	v3alu_pkg::pipe_t              sqrt_s [WB+1];
	logic [NB:0]                   div_vld;
	v3alu_pkg::pipe_t              div_s [NB+1];

	logic                          out_vld_q;
	v3alu_pkg::res_t               out_q;

	logic [WB-1:0]                 xa [6];
	logic [WB-1:0]                 xb [6];
	logic signed [PB-1:0]          prod [6];
	logic [2:0][WB-1:0]            vadd;
	v3alu_pkg::pipe_t              nxt3;
	v3alu_pkg::pipe_t              setup;
	v3alu_pkg::res_t               fin;
	logic signed [SB-1:0]          sum3;
	logic signed [SB-1:0]          dif [3];
	logic signed [SB-1:0]          qx [3];

	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	// operand selection for the six multipliers
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			xa[i] = '0;
			xb[i] = '0;
		end
		case (item_s1.kind)
			v3alu_pkg::K_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					xa[i] = item_s1.a[i];
					xb[i] = item_s1.s;
				end
			end
			v3alu_pkg::K_DOT: begin
				for (int i = 0; i < 3; i++) begin
					xa[i] = item_s1.a[i];
					xb[i] = item_s1.b[i];
				end
			end
			v3alu_pkg::K_SQMAG, v3alu_pkg::K_MAG, v3alu_pkg::K_NORM: begin
				for (int i = 0; i < 3; i++) begin
					xa[i] = item_s1.a[i];
					xb[i] = item_s1.a[i];
				end
			end
			v3alu_pkg::K_CROSS: begin
				xa[0] = item_s1.a[1]; xb[0] = item_s1.b[2];
				xa[1] = item_s1.a[2]; xb[1] = item_s1.b[1];
				xa[2] = item_s1.a[2]; xb[2] = item_s1.b[0];
				xa[3] = item_s1.a[0]; xb[3] = item_s1.b[2];
				xa[4] = item_s1.a[0]; xb[4] = item_s1.b[1];
				xa[5] = item_s1.a[1]; xb[5] = item_s1.b[0];
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 6; i++)
			prod[i] = $signed(xa[i]) * $signed(xb[i]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (item_s1.kind)
				v3alu_pkg::K_ADD: vadd[i] = v3alu_pkg::sat_word(
					v3alu_pkg::sext_word(item_s1.a[i]) + v3alu_pkg::sext_word(item_s1.b[i]));
				v3alu_pkg::K_SUB: vadd[i] = v3alu_pkg::sat_word(
					v3alu_pkg::sext_word(item_s1.a[i]) - v3alu_pkg::sext_word(item_s1.b[i]));
				v3alu_pkg::K_NEG: vadd[i] = v3alu_pkg::sat_word(
					-v3alu_pkg::sext_word(item_s1.a[i]));
				default:          vadd[i] = '0;
			endcase
		end
	end

	// combine products into Q results or the radicand; pass add, sub and neg results on
	always_comb begin
		nxt3      = '0;
		nxt3.kind = kind_s2;
		nxt3.a    = a_s2;
		nxt3.s    = s_s2;
		nxt3.err  = (kind_s2 == v3alu_pkg::K_DIV) && dz_s2;
		sum3 = v3alu_pkg::sext_prod(prod_s2[0]) + v3alu_pkg::sext_prod(prod_s2[1])
			+ v3alu_pkg::sext_prod(prod_s2[2]);
		for (int i = 0; i < 3; i++)
			dif[i] = v3alu_pkg::sext_prod(prod_s2[2*i]) - v3alu_pkg::sext_prod(prod_s2[2*i+1]);
		case (kind_s2)
			v3alu_pkg::K_ADD, v3alu_pkg::K_SUB, v3alu_pkg::K_NEG:
				nxt3.v = vadd_s2;
			v3alu_pkg::K_SCALE: begin
				for (int i = 0; i < 3; i++)
					nxt3.v[i] = v3alu_pkg::sat_word(
						v3alu_pkg::sext_prod(prod_s2[i]) >>> v3alu_pkg::FRAC_BITS);
			end
			v3alu_pkg::K_DOT, v3alu_pkg::K_SQMAG:
				nxt3.sc = v3alu_pkg::sat_word(sum3 >>> v3alu_pkg::FRAC_BITS);
			v3alu_pkg::K_CROSS: begin
				for (int i = 0; i < 3; i++)
					nxt3.v[i] = v3alu_pkg::sat_word(dif[i] >>> v3alu_pkg::FRAC_BITS);
			end
			v3alu_pkg::K_MAG, v3alu_pkg::K_NORM:
				nxt3.n = sum3[PB-1:0];
			default: begin
			end
		endcase
	end

	// divisor, signs, numerators, magnitude and zero-root error once the root is known
	always_comb begin
		setup      = sqrt_s[WB];
		setup.drem = '0;
		setup.quo  = '0;
		for (int i = 0; i < 3; i++)
			setup.num[i] = {v3alu_pkg::abs_word(sqrt_s[WB].a[i]),
				{v3alu_pkg::FRAC_BITS{1'b0}}};
		case (sqrt_s[WB].kind)
			v3alu_pkg::K_MAG:
				setup.sc = sqrt_s[WB].root[WB-1] ? v3alu_pkg::WORD_MAX : sqrt_s[WB].root;
			v3alu_pkg::K_DIV: begin
				setup.d = v3alu_pkg::abs_word(sqrt_s[WB].s);
				for (int i = 0; i < 3; i++)
					setup.neg[i] = sqrt_s[WB].a[i][WB-1] ^ sqrt_s[WB].s[WB-1];
			end
			v3alu_pkg::K_NORM: begin
				setup.d   = sqrt_s[WB].root;
				setup.err = (sqrt_s[WB].root == '0);
				for (int i = 0; i < 3; i++)
					setup.neg[i] = sqrt_s[WB].a[i][WB-1];
			end
			default: begin
			end
		endcase
	end

	// sign, saturate and zero on error
	always_comb begin
		fin.kind = div_s[NB].kind;
		fin.err  = div_s[NB].err;
		fin.v    = div_s[NB].v;
		fin.sc   = div_s[NB].sc;
		for (int i = 0; i < 3; i++)
			qx[i] = {{(SB-NB){1'b0}}, div_s[NB].quo[i]};
		if (div_s[NB].kind == v3alu_pkg::K_DIV || div_s[NB].kind == v3alu_pkg::K_NORM) begin
			for (int i = 0; i < 3; i++)
				fin.v[i] = v3alu_pkg::sat_word(div_s[NB].neg[i] ? -qx[i] : qx[i]);
		end
		if (div_s[NB].err) begin
			fin.v  = '0;
			fin.sc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			sqrt_vld  <= '0;
			div_vld   <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			sqrt_vld  <= {sqrt_vld[WB-1:0], vld_s2};
			div_vld   <= {div_vld[NB-1:0], sqrt_vld[WB]};
			out_vld_q <= div_vld[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			kind_s2 <= item_s1.kind;
			dz_s2   <= item_s1.dz;
			a_s2    <= item_s1.a;
			s_s2    <= item_s1.s;
			vadd_s2 <= vadd;
			for (int i = 0; i < 6; i++)
				prod_s2[i] <= prod[i];
			sqrt_s[0] <= nxt3;
			for (int i = 0; i < WB; i++)
				sqrt_s[i+1] <= v3alu_pkg::sqrt_step(sqrt_s[i]);
			div_s[0] <= setup;
			for (int i = 0; i < NB; i++)
				div_s[i+1] <= v3alu_pkg::div_step(div_s[i]);
			out_q <= fin;
		end
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.err |-> out_q.v == '0 && out_q.sc == '0)
		else $error("error result carries nonzero data");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.kind == v3alu_pkg::K_NONE
		|-> !out_q.err && out_q.v == '0 && out_q.sc == '0)
		else $error("unused operation gave nonzero result");

	a_scalar_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_q.kind == v3alu_pkg::K_DOT || out_q.kind == v3alu_pkg::K_SQMAG
		|| out_q.kind == v3alu_pkg::K_MAG) |-> out_q.v == '0)
		else $error("scalar operation drove the vector result");

endmodule

>>> src/vec3_alu.sv
// ============================================================================
// vec3_alu
// Three-component Q16.16 vector ALU with saturating results.
// ============================================================================
// Path from input word to result word: input queue, operand and product stages,
//   root stages, divide stages and the output register.
// Throughput: one word per cycle, every operation, with no stall on the output.
// Reset: arst_n clears the queue and every pipeline valid bit; data is dropped.
// An output stall freezes the whole back end; the two-word input queue then
// fills and input drops ready until the output moves again.
module vec3_alu (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (lowest bits first)
	input  logic [v3alu_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
	// operation
	input  logic [v3alu_pkg::OP_BITS-1:0]            s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// r_x, r_y, r_z, r_scalar (lowest bits first)
	output logic [v3alu_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
	// error_flag
	output logic [0:0]                               m_axis_tuser
);

	localparam int WB = v3alu_pkg::WORD_BITS;

	logic [2:0][WB-1:0]   in_a;
	logic [2:0][WB-1:0]   in_b;
	logic [WB-1:0]        in_s;
	logic                 q_valid;
	logic                 q_ready;
	v3alu_pkg::item_t     q_item;
	v3alu_pkg::res_t      res;

	// unpack the input word, field by field from the bottom
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_a[i] = s_axis_tdata[i*WB +: WB];
			in_b[i] = s_axis_tdata[(i+3)*WB +: WB];
		end
		in_s = s_axis_tdata[6*WB +: WB];
	end

	// front: accept, decode, queue
	v3alu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_a     (in_a),
		.in_b     (in_b),
		.in_s     (in_s),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// back: arithmetic pipeline with its own output register
	v3alu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// pack the result word, zero pad to whole bytes
	assign m_axis_tdata = v3alu_pkg::OUT_DATA_BITS'({res.sc, res.v[2], res.v[1], res.v[0]});
	assign m_axis_tuser = res.err;

endmodule

>>> test/vec3_alu_test.sv
// ----------------------------------------------------------------------------
// vec3_alu_test
// Self-checking bench for the Q16.16 vector ALU: every accepted input word is
// run through a local predictor and each output word is compared, field by
// field, with the oldest prediction. Directed corner words come first, then
// random words under bursty input, a stalling output and one long output-stall phase.
// ----------------------------------------------------------------------------
module vec3_alu_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = v3alu_pkg::WORD_BITS;
	localparam int F = v3alu_pkg::FRAC_BITS;
	localparam longint WMAXV = (64'sd1 <<< (W - 1)) - 1;
	localparam longint WMINV = -WMAXV - 1;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 530;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0][W-1:0] a;
		logic [2:0][W-1:0] b;
		logic [W-1:0]      s;
	} vec_word_t;

	typedef struct packed {
		logic [2:0][W-1:0] v;
		logic [W-1:0]      sc;
		logic              err;
	} vec_res_t;

	// wide signed helpers for the predictor
	function automatic logic [W-1:0] clamp_word(input logic signed [159:0] x);
		if (x > 160'(WMAXV)) return v3alu_pkg::WORD_MAX;
		if (x < $signed(160'(WMINV))) return v3alu_pkg::WORD_MIN;
		return x[W-1:0];
	endfunction

	function automatic logic signed [159:0] wide(input logic [W-1:0] x);
		return 160'($signed(x));
	endfunction

	function automatic logic signed [159:0] floor_q(input logic signed [159:0] p);
		return p >>> F;
	endfunction

	// (x << F) / d truncated toward zero, saturated
	function automatic logic [W-1:0] quot_q(input logic signed [159:0] x,
		input logic signed [159:0] d);
		logic signed [159:0] n;
		n = x <<< F;
		return clamp_word(n / d);
	endfunction

	function automatic logic [159:0] root_floor(input logic [159:0] n);
		logic [159:0] r, c;
		r = 0;
		for (int k = W; k >= 0; k--) begin
			c = r | (160'd1 << k);
			if (c * c <= n) r = c;
		end
		return r;
	endfunction

	function automatic vec_res_t compute_vec(input vec_word_t w);
		vec_res_t r;
		logic signed [159:0] a[3], b[3], s, acc;
		logic [159:0] m;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			a[i] = wide(w.a[i]);
			b[i] = wide(w.b[i]);
		end
		s = wide(w.s);
		case (w.op)
			v3alu_pkg::OP_ADD:
				for (int i = 0; i < 3; i++) r.v[i] = clamp_word(a[i] + b[i]);
			v3alu_pkg::OP_SUB:
				for (int i = 0; i < 3; i++) r.v[i] = clamp_word(a[i] - b[i]);
			v3alu_pkg::OP_NEG:
				for (int i = 0; i < 3; i++) r.v[i] = clamp_word(-a[i]);
			v3alu_pkg::OP_SCALE:
				for (int i = 0; i < 3; i++) r.v[i] = clamp_word(floor_q(a[i] * s));
			v3alu_pkg::OP_DIV: begin
				if (s == 0) r.err = 1'b1;
				else for (int i = 0; i < 3; i++) r.v[i] = quot_q(a[i], s);
			end
			v3alu_pkg::OP_DOT, v3alu_pkg::OP_SQMAG: begin
				if (w.op == v3alu_pkg::OP_SQMAG) for (int i = 0; i < 3; i++) b[i] = a[i];
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				r.sc = clamp_word(floor_q(acc));
			end
			v3alu_pkg::OP_CROSS: begin
				r.v[0] = clamp_word(floor_q(a[1] * b[2] - a[2] * b[1]));
				r.v[1] = clamp_word(floor_q(a[2] * b[0] - a[0] * b[2]));
				r.v[2] = clamp_word(floor_q(a[0] * b[1] - a[1] * b[0]));
			end
			v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
				acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
				m = root_floor(acc);
				if (w.op == v3alu_pkg::OP_MAG) r.sc = clamp_word($signed(m));
				else if (m == 0) r.err = 1'b1;
				else for (int i = 0; i < 3; i++) r.v[i] = quot_q(a[i], $signed(m));
			end
			default: ;
		endcase
		return r;
	endfunction

	class vec_scoreboard;
		vec_res_t pending[$];
		int       errors;
		int       n_in, n_out;
		int       op_seen[16];

		function void note_word(vec_word_t w);
			pending.push_back(compute_vec(w));
			op_seen[w.op]++;
			n_in++;
		endfunction

		function void check_result(vec_res_t got);
			vec_res_t exp_r;
			n_out++;
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			for (int i = 0; i < 3; i++)
				if (got.v[i] !== exp_r.v[i]) begin
					$error("r_%0s: expected %h, got %h", i == 0 ? "x" : i == 1 ? "y" : "z",
						exp_r.v[i], got.v[i]);
					errors++;
				end
			if (got.sc !== exp_r.sc) begin
				$error("r_scalar: expected %h, got %h", exp_r.sc, got.sc);
				errors++;
			end
			if (got.err !== exp_r.err) begin
				$error("error_flag: expected %b, got %b", exp_r.err, got.err);
				errors++;
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	// a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
	logic [v3alu_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
	logic [v3alu_pkg::OP_BITS-1:0]       s_axis_tuser;   // operation
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	logic [v3alu_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;   // r_x, r_y, r_z, r_scalar
	logic [0:0]                          m_axis_tuser;   // error_flag

	vec3_alu dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	vec_scoreboard board = new();
	bit hold_sink;     // set by the stimulus to ask for a long output stall
	bit stim_done;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random value with frequent corner cases
	function automatic logic [W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return v3alu_pkg::WORD_MAX;
			1: return v3alu_pkg::WORD_MIN;
			2: return '0;
			3: return W'(1) << F;
			4: return W'($signed(-(64'sd1 << F)));
			5: return W'($urandom_range(0, 1 << 20));
			6: return W'(-$signed($urandom_range(0, 1 << 20)));
			default: return W'($urandom());
		endcase
	endfunction

	function automatic vec_word_t random_word();
		vec_word_t w;
		w.op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
			: 4'($urandom_range(0, 9));
		for (int i = 0; i < 3; i++) begin
			w.a[i] = pick_word();
			w.b[i] = pick_word();
		end
		w.s = pick_word();
		return w;
	endfunction

	// offer one word and hold it until it is taken
	task automatic send_word(input vec_word_t w);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.op;
		s_axis_tdata  <= v3alu_pkg::IN_DATA_BITS'({w.s, w.b[2], w.b[1], w.b[0],
			w.a[2], w.a[1], w.a[0]});
		do @(posedge clk); while (!s_axis_tready);
		board.note_word(w);
	endtask

	task automatic pause_send(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic vec_word_t make_word(input logic [3:0] op,
		input logic [W-1:0] ax, input logic [W-1:0] ay, input logic [W-1:0] az,
		input logic [W-1:0] bx, input logic [W-1:0] by, input logic [W-1:0] bz,
		input logic [W-1:0] s);
		vec_word_t w;
		w.op = op;
		w.a = {az, ay, ax};
		w.b = {bz, by, bx};
		w.s = s;
		return w;
	endfunction

	// sender
	initial begin
		logic [W-1:0] one;
		logic [W-1:0] wmax;
		logic [W-1:0] wmin;
		int burst;
		one  = W'(1) << F;
		wmax = v3alu_pkg::WORD_MAX;
		wmin = v3alu_pkg::WORD_MIN;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		hold_sink     = 1'b0;
		stim_done     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: every operation, the extremes and each special case
		send_word(make_word(v3alu_pkg::OP_ADD, wmax, wmin, one, wmax, wmin, one, 0));
		send_word(make_word(v3alu_pkg::OP_SUB, wmax, wmin, 0, wmin, wmax, one, 0));
		send_word(make_word(v3alu_pkg::OP_NEG, wmin, wmax, 0, 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_SCALE, wmax, wmin, W'(-1), 0, 0, 0, wmax));
		send_word(make_word(v3alu_pkg::OP_SCALE, one, W'(-1), W'(3), 0, 0, 0, W'(-1)));
		send_word(make_word(v3alu_pkg::OP_DIV, one, wmin, wmax, 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_DIV, wmax, wmin, W'(-7), 0, 0, 0, W'(1)));
		send_word(make_word(v3alu_pkg::OP_DIV, wmin, one, W'(7), 0, 0, 0, W'(-1)));
		send_word(make_word(v3alu_pkg::OP_DOT, wmax, wmax, wmax, wmax, wmax, wmax, 0));
		send_word(make_word(v3alu_pkg::OP_DOT, wmin, one, 0, wmax, W'(-1), 0, 0));
		send_word(make_word(v3alu_pkg::OP_SQMAG, wmin, wmin, wmin, 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_SQMAG, one, W'(2), W'(-3), 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_CROSS, wmax, wmin, one, wmin, wmax, W'(-1), 0));
		send_word(make_word(v3alu_pkg::OP_MAG, wmin, wmin, wmin, 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_MAG, W'(3), 0, 0, 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_NORM, 0, 0, 0, one, one, one, one));
		send_word(make_word(v3alu_pkg::OP_NORM, W'(1), 0, 0, 0, 0, 0, 0));
		send_word(make_word(v3alu_pkg::OP_NORM, wmax, wmin, one, 0, 0, 0, 0));
		send_word(make_word(4'd10, one, one, one, one, one, one, one));
		send_word(make_word(4'd15, wmax, wmin, 0, 0, 0, 0, wmin));

		// hold until the pipeline has drained completely
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);

		// ask for a long output stall and keep offering words through it
		hold_sink <= 1'b1;
		for (int i = 0; i < 150; i++) send_word(random_word());
		hold_sink <= 1'b0;

		// random bursts with random gaps, some stretches without gaps
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) send_word(random_word());
			if ($urandom_range(0, 3) != 0) pause_send($urandom_range(1, 12));
		end
		s_axis_tvalid <= 1'b0;
		stim_done <= 1'b1;
	end

	// receiver: own stall pattern, plus the long hold requested above
	initial begin
		int hold_count;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink && hold_count < 400) begin
				hold_count++;
				m_axis_tready <= 1'b0;
			end else if (($urandom_range(0, 255) & 8'hc0) == 0) begin
				m_axis_tready <= 1'b1;   // ready for this cycle
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// sample results and run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_result({m_axis_tdata[3*W-1:0], m_axis_tdata[4*W-1:3*W],
					m_axis_tuser[0]});
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end else begin
			idle_cycles <= 0;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stim_done && board.pending.size() == 0) begin
				repeat (2 * W + F + 20) @(posedge clk);
				$display("covered %0d input words, %0d result words checked",
					board.n_in, board.n_out);
				$display("ops 0..9 seen: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
					board.op_seen[0], board.op_seen[1], board.op_seen[2], board.op_seen[3],
					board.op_seen[4], board.op_seen[5], board.op_seen[6], board.op_seen[7],
					board.op_seen[8], board.op_seen[9]);
				if (board.errors == 0 && board.pending.size() == 0)
					$display("PASS vec3_alu");
				else
					$display("FAIL vec3_alu");
				$finish;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("FAIL vec3_alu");
				$finish;
			end
		end
	end

endmodule
